@@ src/metric_aggregation_table_core_assert.svh @@
// Assertion macros for the table back end. Both forms expect a clock
// named clk in scope; MAT_ASSERT also expects a reset named rst.
`ifndef METRIC_AGGREGATION_TABLE_CORE_ASSERT_SVH
`define METRIC_AGGREGATION_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MAT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MAT_ASSERT(lbl, prop, msg)
`define MAT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ src/mat_pkg.sv @@
`default_nettype none
package mat_pkg;

  localparam int METRIC_IDS = 256;
  localparam int ID_W       = (METRIC_IDS > 1) ? $clog2(METRIC_IDS) : 1;
  localparam int Q_DEPTH    = 2;

  localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [31:0]        CNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_COUNTER = 2'd0,
    OP_GAUGE   = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  // What the back end has to do with a queued command.
  typedef enum logic [1:0] {
    KIND_COUNTER   = 2'd0,
    KIND_GAUGE     = 2'd1,
    KIND_READ      = 2'd2,
    KIND_READ_NULL = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   idx;
    logic [31:0]       inc;
    logic [31:0]       value;
  } cmd_t;

  typedef struct packed {
    logic [31:0] last;
    logic [31:0] max;
    logic [31:0] min;
    logic [63:0] sum;
    logic [31:0] count;
  } gauge_t;

  typedef enum logic {
    ST_READ = 1'b0,
    ST_EXEC = 1'b1
  } st_t;

endpackage
`default_nettype wire

@@ src/mat_front.sv @@
`default_nettype none
module mat_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [71:0]   s_tdata,
  input  wire logic [1:0]    s_tuser,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output mat_pkg::cmd_t      cmd
);
  import mat_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic  [7:0]  id_in;
  logic         id_ok;
  logic         keep;
  kind_t        kind;
  cmd_t         cmd_in;
  logic         push;
  logic         pop;

  assign id_in = s_tdata[7:0];
  assign id_ok = (32'(id_in) < METRIC_IDS);

  // Updates to ids outside the table and the unused code are dropped here;
  // a read of such an id still yields an all-zero result.
  always_comb begin
    keep = 1'b0;
    kind = KIND_READ_NULL;
    unique case (s_tuser)
      OP_COUNTER: begin
        keep = id_ok;
        kind = KIND_COUNTER;
      end
      OP_GAUGE: begin
        keep = id_ok;
        kind = KIND_GAUGE;
      end
      OP_READ: begin
        keep = 1'b1;
        kind = id_ok ? KIND_READ : KIND_READ_NULL;
      end
      default: begin
        keep = 1'b0;
        kind = KIND_READ_NULL;
      end
    endcase
  end

  always_comb begin
    cmd_in.kind  = kind;
    cmd_in.idx   = ID_W'(id_in);
    cmd_in.inc   = s_tdata[39:8];
    cmd_in.value = s_tdata[71:40];
  end

  assign s_tready  = (count != CNT_W'(Q_DEPTH));
  assign push      = s_tvalid && s_tready && keep;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/mat_back.sv @@
`default_nettype none
module mat_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire mat_pkg::cmd_t cmd,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [255:0]       m_tdata,
  output logic [0:0]         m_tuser
);
  import mat_pkg::*;

  logic [63:0] ctr_mem [METRIC_IDS];
  gauge_t      g_mem   [METRIC_IDS];

  logic [METRIC_IDS-1:0] ctr_seen;
  logic [METRIC_IDS-1:0] g_seen;

  st_t    state;
  st_t    state_next;
  cmd_t   cur;
  logic [63:0] ctr_rd;
  gauge_t g_rd;

  logic   out_free;
  logic   fire;
  logic   ctr_we;
  logic   g_we;
  logic   rd_load;
  logic   is_read;
  logic   clear_entry;

  logic        cur_cseen;
  logic        cur_gseen;
  logic [63:0] ctr_new;
  gauge_t      g_new;
  logic [63:0] v_ext;
  logic [63:0] sum_raw;
  logic        sum_ovf;
  logic [255:0] res_data;

  assign out_free  = !m_tvalid || m_tready;
  assign cur_cseen = ctr_seen[cur.idx];
  assign cur_gseen = g_seen[cur.idx];
  assign is_read   = (cur.kind == KIND_READ) || (cur.kind == KIND_READ_NULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READ;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd_ready   = 1'b0;
    fire        = 1'b0;
    ctr_we      = 1'b0;
    g_we        = 1'b0;
    rd_load     = 1'b0;
    clear_entry = 1'b0;
    unique case (state)
      ST_READ: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        fire = !is_read || out_free;
        if (fire) begin
          state_next = ST_READ;
          unique case (cur.kind)
            KIND_COUNTER:   ctr_we = 1'b1;
            KIND_GAUGE:     g_we   = 1'b1;
            KIND_READ: begin
              rd_load     = 1'b1;
              clear_entry = 1'b1;
            end
            KIND_READ_NULL: rd_load = 1'b1;
          endcase
        end
      end
    endcase
  end

  // Entry read is registered; the write of the updated entry follows in the
  // next cycle, before the next command reads the table.
  always_ff @(posedge clk) begin
    if (state == ST_READ && cmd_valid) begin
      cur    <= cmd;
      ctr_rd <= ctr_mem[cmd.idx];
      g_rd   <= g_mem[cmd.idx];
    end
  end

  always_comb begin
    ctr_new = cur_cseen ? ctr_rd + 64'(cur.inc) : 64'(cur.inc);
  end

  always_comb begin
    v_ext   = {{32{cur.value[31]}}, cur.value};
    sum_raw = g_rd.sum + v_ext;
    sum_ovf = (g_rd.sum[63] == cur.value[31]) && (sum_raw[63] != g_rd.sum[63]);
    g_new.last = cur.value;
    if (!cur_gseen) begin
      g_new.count = 32'd1;
      g_new.sum   = v_ext;
      g_new.min   = cur.value;
      g_new.max   = cur.value;
    end else begin
      g_new.count = (g_rd.count == CNT_MAX) ? g_rd.count : g_rd.count + 32'd1;
      if (sum_ovf) begin
        g_new.sum = g_rd.sum[63] ? SUM_MIN : SUM_MAX;
      end else begin
        g_new.sum = sum_raw;
      end
      g_new.min = ($signed(cur.value) < $signed(g_rd.min)) ? cur.value : g_rd.min;
      g_new.max = ($signed(cur.value) > $signed(g_rd.max)) ? cur.value : g_rd.max;
    end
  end

  always_ff @(posedge clk) begin
    if (ctr_we) begin
      ctr_mem[cur.idx] <= ctr_new;
    end
    if (g_we) begin
      g_mem[cur.idx] <= g_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_seen <= '0;
      g_seen   <= '0;
    end else begin
      if (ctr_we) begin
        ctr_seen[cur.idx] <= 1'b1;
      end
      if (g_we) begin
        g_seen[cur.idx] <= 1'b1;
      end
      if (clear_entry) begin
        ctr_seen[cur.idx] <= 1'b0;
        g_seen[cur.idx]   <= 1'b0;
      end
    end
  end

  // Result fields from the lowest bit: counter_total, gauge_count, gauge_sum,
  // gauge_min, gauge_max, gauge_last. Absent aggregates read as zero.
  always_comb begin
    res_data = '0;
    if (cur.kind == KIND_READ) begin
      if (cur_cseen) begin
        res_data[63:0] = ctr_rd;
      end
      if (cur_gseen) begin
        res_data[95:64]   = g_rd.count;
        res_data[159:96]  = g_rd.sum;
        res_data[191:160] = g_rd.min;
        res_data[223:192] = g_rd.max;
        res_data[255:224] = g_rd.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_load) begin
      m_tdata    <= res_data;
      m_tuser[0] <= (cur.kind == KIND_READ) && cur_cseen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rd_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`include "metric_aggregation_table_core_assert.svh"

  `MAT_ASSERT_RST(a_reset_idle, rst |=> (state == ST_READ) && !m_tvalid, "reset left back end busy")
  `MAT_ASSERT(a_read_clears, clear_entry |=> !ctr_seen[$past(cur.idx)] && !g_seen[$past(cur.idx)], "read did not clear entry")
  `MAT_ASSERT(a_gauge_sets, g_we |=> g_seen[$past(cur.idx)], "gauge update left entry empty")
  `MAT_ASSERT(a_no_overwrite, (m_tvalid && !m_tready) |-> !rd_load, "result overwritten while stalled")

endmodule
`default_nettype wire

@@ src/metric_aggregation_table_core.sv @@
`default_nettype none
// Per-id counter and gauge aggregation table.
// Input stream: s_tuser carries the operation (counter add, gauge sample,
// read and clear); s_tdata carries metric_id, counter_increment and the
// Q16.16 gauge_value. Updates produce no output; each read produces one
// transfer on the output stream, with counter_present in m_tuser and the
// counter total and gauge count, sum, min, max and last value in m_tdata.
// A short command queue decouples the input from the table engine, which
// handles each command by reading its table entry into a register and
// then writing back the updated entry or loading the result. The engine
// takes a new command only after it is through with the last one. A read
// result passes through the command queue, the entry register and the
// output register, and waits behind every command still ahead of it.
// Commands that are dropped (unused operation, update of an id outside the
// table) are accepted on the input and never enter the queue.
// Reset clears all presence flags, the queue and the output valid flag, so
// every entry starts empty; no clearing pass is needed.
// While the output is stalled the result register holds, the engine waits
// on the next read, and the queue fills before s_tready drops.
module metric_aggregation_table_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [71:0]  s_tdata,   // metric_id, counter_increment, gauge_value
  input  wire logic [1:0]   s_tuser,   // operation
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [255:0]      m_tdata,   // counter_total, gauge_count, gauge_sum,
                                       // gauge_min, gauge_max, gauge_last
  output logic [0:0]        m_tuser    // counter_present
);
  import mat_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  mat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  mat_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire
